/* rtl/srmsd_pkg.sv */
package srmsd_pkg;

  localparam int ROWS       = 1024;
  localparam int ADDR_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_W      = 10;
  localparam int VAL_W      = 24;
  localparam int SQR_W      = 2 * VAL_W;
  localparam int SUM_W      = 40;
  localparam int SQ_W       = 64;
  localparam int WORD_W     = SUM_W + SQ_W;
  localparam int N_W        = 16;
  localparam int MEAN_W     = 24;
  localparam int SD_W       = 23;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int DIV_STEPS  = SQ_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [N_W-1:0] N_MIN = N_W'(2);

  localparam logic [1:0] MODE_ACC   = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } op_t;

  // request to the shared divide / square-root unit
  typedef struct packed {
    logic            start;
    op_t             op;
    logic [SQ_W-1:0] x;
    logic [N_W-1:0]  d;
  } iter_req_t;

endpackage

/* rtl/sparse_row_mean_and_std_dev.sv */
// Sparse row mean and sample standard deviation.
// Command channel: present mode, row_index and entry_value with start high;
// the command transfers at a clock edge where start is high and busy is low.
// Modes: accumulate adds the value and its square into the row sums, query
// returns the row mean and sample standard deviation, clear zeroes a row.
// Config channel: cfg_data carries the draw count, written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write it only while idle.
// Results: a query gives one result on mean_value / std_dev for exactly one
// cycle, marked by done; the receiver cannot stall it. Other modes give none.
// Busy: accumulate keeps busy high through a RAM read and a write back, and
// clear through a single RAM write.
// A query keeps busy high through a RAM read, a load, a 64-step divide for the
// mean, two multiply steps, a load, a 64-step divide for the variance and a
// 32-step square root, all on one shared restoring unit; done pulses in the
// first cycle with busy low.
// Reset: the draw count returns to 2, and a clearing pass writes zero to every
// row, one row per cycle; busy stays high during the pass.
module sparse_row_mean_and_std_dev (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [srmsd_pkg::ROW_W-1:0]   row_index,
  input  logic signed [srmsd_pkg::VAL_W-1:0] entry_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srmsd_pkg::N_W-1:0]     cfg_data,
  output logic                          done,
  output logic signed [srmsd_pkg::MEAN_W-1:0] mean_value,
  output logic [srmsd_pkg::SD_W-1:0]    std_dev
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_READ  = 12'b0000_0000_0100,
    S_ACC   = 12'b0000_0000_1000,
    S_ZERO  = 12'b0000_0001_0000,
    S_QLOAD = 12'b0000_0010_0000,
    S_MDIV  = 12'b0000_0100_0000,
    S_SQ1   = 12'b0000_1000_0000,
    S_SQ2   = 12'b0001_0000_0000,
    S_VAR   = 12'b0010_0000_0000,
    S_VDIV  = 12'b0100_0000_0000,
    S_SQRT  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  logic [srmsd_pkg::ADDR_W-1:0]     clr_addr;
  logic [srmsd_pkg::N_W-1:0]        n_draws;
  logic [srmsd_pkg::N_W-1:0]        n_eff;

  logic [1:0]                       mode_r;
  logic [srmsd_pkg::ROW_W-1:0]      row_r;
  logic [srmsd_pkg::VAL_W-1:0]      val_r;
  logic [srmsd_pkg::VAL_W-1:0]      val_mag;
  logic [srmsd_pkg::SQR_W-1:0]      sq;
  logic                             row_ok;

  logic                             ram_we;
  logic [srmsd_pkg::ADDR_W-1:0]     ram_waddr;
  logic [srmsd_pkg::WORD_W-1:0]     ram_wdata;
  logic [srmsd_pkg::WORD_W-1:0]     ram_rdata;

  logic [srmsd_pkg::SUM_W-1:0]      rd_sum;
  logic [srmsd_pkg::SQ_W-1:0]       rd_sq;
  logic [srmsd_pkg::SUM_W:0]        sum_ext;
  logic [srmsd_pkg::SUM_W-1:0]      sum_new;
  logic [srmsd_pkg::SQ_W:0]         sq_ext;
  logic [srmsd_pkg::SQ_W-1:0]       sq_new;
  logic [srmsd_pkg::SUM_W-1:0]      sum_mag;

  logic [srmsd_pkg::SQ_W-1:0]       ss_r;
  logic                             sneg;
  logic [srmsd_pkg::MEAN_W-1:0]     m_mag;
  logic [srmsd_pkg::MEAN_W-1:0]     m_mag_next;
  logic [srmsd_pkg::MEAN_W-1:0]     mean_r;
  logic [srmsd_pkg::SQR_W-1:0]      m2;
  logic [srmsd_pkg::SQ_W-1:0]       t;
  logic [srmsd_pkg::SD_W-1:0]       sd_sat;

  srmsd_pkg::iter_req_t             req;
  logic                             iter_done;
  logic [srmsd_pkg::SQ_W-1:0]       iter_quo;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign n_eff     = (n_draws < srmsd_pkg::N_MIN) ? srmsd_pkg::N_MIN : n_draws;
  assign row_ok    = (32'(row_index) < 32'(srmsd_pkg::ROWS));
  assign val_mag   = val_r[srmsd_pkg::VAL_W-1] ? (~val_r + 1'b1) : val_r;

  assign rd_sum  = ram_rdata[srmsd_pkg::WORD_W-1 -: srmsd_pkg::SUM_W];
  assign rd_sq   = ram_rdata[srmsd_pkg::SQ_W-1:0];
  assign sum_mag = rd_sum[srmsd_pkg::SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;

  // saturating row update
  always_comb begin
    sum_ext = {rd_sum[srmsd_pkg::SUM_W-1], rd_sum}
            + {{(srmsd_pkg::SUM_W + 1 - srmsd_pkg::VAL_W){val_r[srmsd_pkg::VAL_W-1]}}, val_r};
    if (sum_ext[srmsd_pkg::SUM_W] != sum_ext[srmsd_pkg::SUM_W-1]) begin
      sum_new = sum_ext[srmsd_pkg::SUM_W]
              ? {1'b1, {(srmsd_pkg::SUM_W-1){1'b0}}}
              : {1'b0, {(srmsd_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_new = sum_ext[srmsd_pkg::SUM_W-1:0];
    end
    sq_ext = {1'b0, rd_sq} + (srmsd_pkg::SQ_W + 1)'(sq);
    sq_new = sq_ext[srmsd_pkg::SQ_W] ? '1 : sq_ext[srmsd_pkg::SQ_W-1:0];
  end

  // mean magnitude clamp to the signed output range, and std_dev saturation
  always_comb begin
    if (sneg) begin
      m_mag_next = (iter_quo > srmsd_pkg::SQ_W'(1 << (srmsd_pkg::MEAN_W - 1)))
                 ? {1'b1, {(srmsd_pkg::MEAN_W-1){1'b0}}}
                 : iter_quo[srmsd_pkg::MEAN_W-1:0];
    end else begin
      m_mag_next = (iter_quo > srmsd_pkg::SQ_W'((1 << (srmsd_pkg::MEAN_W - 1)) - 1))
                 ? {1'b0, {(srmsd_pkg::MEAN_W-1){1'b1}}}
                 : iter_quo[srmsd_pkg::MEAN_W-1:0];
    end
    sd_sat = (iter_quo > srmsd_pkg::SQ_W'((1 << srmsd_pkg::SD_W) - 1))
           ? '1 : iter_quo[srmsd_pkg::SD_W-1:0];
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = srmsd_pkg::ADDR_W'(row_r);
    ram_wdata  = {sum_new, sq_new};
    req        = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == srmsd_pkg::ADDR_W'(srmsd_pkg::ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            srmsd_pkg::MODE_ACC: begin
              if (row_ok) state_next = S_READ;
            end
            srmsd_pkg::MODE_QUERY: begin
              if (row_ok) begin
                state_next = S_READ;
              end else begin
                done_next = 1'b1;
              end
            end
            srmsd_pkg::MODE_CLEAR: begin
              if (row_ok) state_next = S_ZERO;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        state_next = (mode_r == srmsd_pkg::MODE_QUERY) ? S_QLOAD : S_ACC;
      end
      S_ACC: begin
        ram_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_ZERO: begin
        ram_we     = 1'b1;
        ram_wdata  = '0;
        state_next = S_IDLE;
      end
      S_QLOAD: begin
        req.start  = 1'b1;
        req.op     = srmsd_pkg::OP_DIV;
        req.x      = srmsd_pkg::SQ_W'(sum_mag);
        req.d      = n_eff;
        state_next = S_MDIV;
      end
      S_MDIV: begin
        if (iter_done) state_next = S_SQ1;
      end
      S_SQ1: begin
        state_next = S_SQ2;
      end
      S_SQ2: begin
        state_next = S_VAR;
      end
      S_VAR: begin
        req.start  = 1'b1;
        req.op     = srmsd_pkg::OP_DIV;
        req.x      = (ss_r > t) ? (ss_r - t) : '0;
        req.d      = n_eff - 1'b1;
        state_next = S_VDIV;
      end
      S_VDIV: begin
        if (iter_done) begin
          req.start  = 1'b1;
          req.op     = srmsd_pkg::OP_SQRT;
          req.x      = iter_quo;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (iter_done) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      n_draws  <= srmsd_pkg::N_MIN;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        n_draws <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      mode_r <= mode;
      row_r  <= row_index;
      val_r  <= entry_value;
      if (mode == srmsd_pkg::MODE_QUERY && !row_ok) begin
        mean_value <= '0;
        std_dev    <= '0;
      end
    end
    if (state == S_READ) begin
      sq <= val_mag * val_mag;
    end
    if (state == S_QLOAD) begin
      ss_r <= rd_sq;
      sneg <= rd_sum[srmsd_pkg::SUM_W-1];
    end
    if (state == S_MDIV && iter_done) begin
      m_mag  <= m_mag_next;
      mean_r <= sneg ? (~m_mag_next + 1'b1) : m_mag_next;
    end
    if (state == S_SQ1) begin
      m2 <= m_mag * m_mag;
    end
    if (state == S_SQ2) begin
      t <= m2 * n_eff;
    end
    if (state == S_SQRT && iter_done) begin
      mean_value <= mean_r;
      std_dev    <= sd_sat;
    end
  end

  srmsd_ram #(
    .WIDTH (srmsd_pkg::WORD_W),
    .DEPTH (srmsd_pkg::ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (srmsd_pkg::ADDR_W'(row_r)),
    .rdata (ram_rdata)
  );

  srmsd_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (iter_done),
    .quo  (iter_quo)
  );

endmodule

/* rtl/srmsd_ram.sv */
module srmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/srmsd_iter.sv */
module srmsd_iter (
  input  logic                        clk,
  input  logic                        rst,
  input  srmsd_pkg::iter_req_t        req,
  output logic                        done,
  output logic [srmsd_pkg::SQ_W-1:0]  quo
);

  logic                            active;
  logic [srmsd_pkg::CNT_W-1:0]     cnt;
  srmsd_pkg::op_t                  op;
  logic [srmsd_pkg::SQ_W-1:0]      x;
  logic [srmsd_pkg::N_W-1:0]       d;
  logic [srmsd_pkg::REM_W-1:0]     rem;
  logic [srmsd_pkg::REM_W-1:0]     shifted;
  logic [srmsd_pkg::REM_W-1:0]     trial;
  logic                            ge;

  // one restoring step: radix-2 divide or radix-4 digit-by-digit root
  always_comb begin
    if (op == srmsd_pkg::OP_SQRT) begin
      shifted = {rem[srmsd_pkg::REM_W-3:0], x[srmsd_pkg::SQ_W-1 -: 2]};
      trial   = {1'b0, quo[srmsd_pkg::ROOT_W-1:0], 2'b01};
    end else begin
      shifted = {rem[srmsd_pkg::REM_W-2:0], x[srmsd_pkg::SQ_W-1]};
      trial   = srmsd_pkg::REM_W'(d);
    end
    ge = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= (req.op == srmsd_pkg::OP_SQRT) ? srmsd_pkg::CNT_W'(srmsd_pkg::SQRT_STEPS)
                                                 : srmsd_pkg::CNT_W'(srmsd_pkg::DIV_STEPS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == srmsd_pkg::CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      x   <= req.x;
      d   <= req.d;
      rem <= '0;
      quo <= '0;
    end else if (active) begin
      if (op == srmsd_pkg::OP_SQRT) begin
        x <= {x[srmsd_pkg::SQ_W-3:0], 2'b00};
      end else begin
        x <= {x[srmsd_pkg::SQ_W-2:0], 1'b0};
      end
      rem <= ge ? (shifted - trial) : shifted;
      quo <= {quo[srmsd_pkg::SQ_W-2:0], ge};
    end
  end

endmodule
